>>> design/imufoc_pkg.sv
package imufoc_pkg;

	// Frame lengths in bytes
	localparam logic [4:0] FULL_FRAME_BYTES  = 5'd20;
	localparam logic [4:0] SHORT_FRAME_BYTES = 5'd14;

	// Word slot of the temperature reading, consumed without a result
	localparam logic [3:0] WORD_TEMP = 4'd3;

	// Sensor kinds
	localparam logic [1:0] KIND_ACCEL = 2'd0;
	localparam logic [1:0] KIND_GYRO  = 2'd1;
	localparam logic [1:0] KIND_MAG   = 2'd2;

	// Axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_FRAME_MODE    = 3'd0;
	localparam logic [2:0] REG_ACCEL_OFFSETS = 3'd1;
	localparam logic [2:0] REG_GYRO_OFFSETS  = 3'd2;
	localparam logic [2:0] REG_MAG_OFFSETS   = 3'd3;
	localparam logic [2:0] REG_MAG_GAINS     = 3'd4;

	localparam logic [47:0] MAG_GAINS_RESET = 48'h0010_0010_0010;

	// Queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// One classified axis word
	typedef struct packed {
		logic [15:0] raw;
		logic [1:0]  kind;
		logic [1:0]  axis;
		logic        last;
	} item_t;

	// Correction coefficients
	typedef struct packed {
		logic [47:0] accel_off;
		logic [47:0] gyro_off;
		logic [47:0] mag_off;
		logic [47:0] mag_gain;
	} corr_cfg_t;

	// Pick one 16-bit lane of a packed triple
	function automatic logic [15:0] lane16(input logic [47:0] packed_v, input logic [1:0] ax);
		logic [15:0] r;
		case (ax)
			AXIS_X:  r = packed_v[15:0];
			AXIS_Y:  r = packed_v[31:16];
			default: r = packed_v[47:32];
		endcase
		return r;
	endfunction

endpackage

>>> design/imufoc_fifo.sv
module imufoc_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  imufoc_pkg::item_t   wr_item,
	input  logic                rd_en,
	output imufoc_pkg::item_t   rd_item,
	output logic                q_full,
	output logic                q_empty
);
	import imufoc_pkg::*;

	item_t           entry_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign q_full  = (count_q == Q_CW'(Q_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_item = entry_q[rd_ptr_q];

	// Store incoming request
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/imufoc_front.sv
module imufoc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              first_byte,
	input  logic              frame_mode,
	output logic              push,
	output imufoc_pkg::item_t item
);
	import imufoc_pkg::*;

	logic [4:0] pos_q;
	logic [7:0] hold_q;
	logic [4:0] frame_len;
	logic [4:0] idx;
	logic [4:0] nxt;
	logic [3:0] word;
	logic       active;
	logic       in_frame;

	assign frame_len = frame_mode ? SHORT_FRAME_BYTES : FULL_FRAME_BYTES;
	assign active    = first_byte || (pos_q != '0);
	assign idx       = first_byte ? 5'd0 : pos_q;
	assign in_frame  = (idx < frame_len);
	assign nxt       = idx + 5'd1;
	assign word      = idx[4:1];

	// Emit a request on the low byte of every axis word
	assign push     = accept && active && in_frame && idx[0] && (word != WORD_TEMP);

	// Classify word slot into sensor and axis
	always_comb begin
		item.raw  = {hold_q, data_byte};
		item.last = (nxt == frame_len);
		unique case (word) inside
			4'd0, 4'd1, 4'd2: begin
				item.kind = KIND_ACCEL;
				item.axis = word[1:0];
			end
			4'd4, 4'd5, 4'd6: begin
				item.kind = KIND_GYRO;
				item.axis = 2'(word - 4'd4);
			end
			4'd7, 4'd8, 4'd9: begin
				item.kind = KIND_MAG;
				item.axis = 2'(word - 4'd7);
			end
			default: begin
				item.kind = KIND_ACCEL;
				item.axis = AXIS_X;
			end
		endcase
	end

	// Track byte position and hold the high byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hold_q <= '0;
		end else if (accept && active) begin
			if (!in_frame) begin
				pos_q <= '0;
			end else begin
				pos_q <= (nxt >= frame_len) ? 5'd0 : nxt;
				if (!idx[0]) begin
					hold_q <= data_byte;
				end
			end
		end
	end

endmodule

>>> design/imufoc_back.sv
module imufoc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  imufoc_pkg::corr_cfg_t cfg,
	input  logic                  q_empty,
	input  imufoc_pkg::item_t     q_item,
	output logic                  q_pop,
	output logic                  s1_hold,
	input  logic                  pop,
	output logic                  empty,
	output logic [1:0]            sensor_kind,
	output logic [1:0]            axis,
	output logic signed [15:0]    value,
	output logic                  last_of_frame
);
	import imufoc_pkg::*;

	logic        v_s1;
	logic [15:0] val_s1;
	logic [15:0] gain_s1;
	logic        mag_s1;
	logic [1:0]  kind_s1;
	logic [1:0]  axis_s1;
	logic        last_s1;
	logic        v_s2;

	logic        adv_s2;
	logic        adv_s1;
	logic        is_mag;
	logic [15:0] raw_adj;
	logic [15:0] off;
	logic [31:0] prod;

	// Pipeline flow control
	assign adv_s2  = !v_s2 || pop;
	assign adv_s1  = v_s1 && adv_s2;
	assign q_pop   = !q_empty && (!v_s1 || adv_s2);
	assign s1_hold = v_s1 && !adv_s2;
	assign empty   = !v_s2;

	// Negate mag z, then subtract the offset
	assign is_mag  = (q_item.kind == KIND_MAG);
	assign raw_adj = (is_mag && q_item.axis == AXIS_Z) ? 16'(16'd0 - q_item.raw) : q_item.raw;

	always_comb begin
		case (q_item.kind)
			KIND_ACCEL: off = lane16(cfg.accel_off, q_item.axis);
			KIND_GYRO:  off = lane16(cfg.gyro_off, q_item.axis);
			default:    off = lane16(cfg.mag_off, q_item.axis);
		endcase
	end

	assign prod = val_s1 * gain_s1;

	// Stage 1: offset correction
	always_ff @(posedge clk) begin
		if (q_pop) begin
			val_s1  <= 16'(raw_adj - off);
			gain_s1 <= lane16(cfg.mag_gain, q_item.axis);
			mag_s1  <= is_mag;
			kind_s1 <= q_item.kind;
			axis_s1 <= q_item.axis;
			last_s1 <= q_item.last;
		end
	end

	// Stage 2: gain on mag axes, result register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			value         <= mag_s1 ? prod[15:0] : val_s1;
			sensor_kind   <= kind_s1;
			axis          <= axis_s1;
			last_of_frame <= last_s1;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (q_pop) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (pop) begin
				v_s2 <= 1'b0;
			end
		end
	end

endmodule

>>> design/imu_frame_offset_correction_core.sv
// Sensor burst byte stream to corrected axis readings.
// Throughput: one byte per cycle while not full, set by the front byte tracker; results drain one per cycle.
// Path: the edge that accepts the low byte of a word writes it into the queue, then it passes the
// offset stage and the gain/result stage (16x16 multiply); a full result register stalls both.
// Reset: arst_n clears frame position, queue pointers and valid bits; config registers take reset values.
module imu_frame_offset_correction_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	input  logic               first_byte,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         sensor_kind,
	output logic [1:0]         axis,
	output logic signed [15:0] value,
	output logic               last_of_frame,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);
	import imufoc_pkg::*;

	logic      frame_mode_q;
	corr_cfg_t cfg_q;
	logic      cfg_wr;
	logic [2:0] reg_idx;

	logic  accept;
	logic  f_push;
	item_t f_item;
	item_t q_item;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;
	logic  s1_hold;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q   <= 1'b0;
			cfg_q.accel_off <= '0;
			cfg_q.gyro_off  <= '0;
			cfg_q.mag_off   <= '0;
			cfg_q.mag_gain  <= MAG_GAINS_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FRAME_MODE:    frame_mode_q    <= pwdata[0];
				REG_ACCEL_OFFSETS: cfg_q.accel_off <= pwdata[47:0];
				REG_GYRO_OFFSETS:  cfg_q.gyro_off  <= pwdata[47:0];
				REG_MAG_OFFSETS:   cfg_q.mag_off   <= pwdata[47:0];
				REG_MAG_GAINS:     cfg_q.mag_gain  <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_MODE:    prdata = {63'd0, frame_mode_q};
			REG_ACCEL_OFFSETS: prdata = {16'd0, cfg_q.accel_off};
			REG_GYRO_OFFSETS:  prdata = {16'd0, cfg_q.gyro_off};
			REG_MAG_OFFSETS:   prdata = {16'd0, cfg_q.mag_off};
			REG_MAG_GAINS:     prdata = {16'd0, cfg_q.mag_gain};
			default:           prdata = '0;
		endcase
	end

	// Input side looks full when the queue is full
	assign full   = q_full;
	assign accept = push && !full;

	imufoc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.frame_mode (frame_mode_q),
		.push       (f_push),
		.item       (f_item)
	);

	imufoc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_item (f_item),
		.rd_en   (q_pop),
		.rd_item (q_item),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	imufoc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.s1_hold       (s1_hold),
		.pop           (pop),
		.empty         (empty),
		.sensor_kind   (sensor_kind),
		.axis          (axis),
		.value         (value),
		.last_of_frame (last_of_frame)
	);

	// A classified request never meets a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> !q_full)
		else $error("front pushed into full queue");

	// Back end only draws from a non-empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back popped empty queue");

	// A stalled offset stage implies a held result: the output stays non-empty
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_hold |=> !empty)
		else $error("offset stage dropped a request");

endmodule
